### sv/smi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small matrix inverse package
// Widths, pipeline depths and element types shared by the inverse unit.
// ----------------------------------------------------------------------------
package smi_pkg;
    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 64;
    localparam int COF_W     = 65;
    localparam int DET_W     = 98;
    localparam int DIV_STEPS = 32;
    localparam int N_LANES   = 9;
    localparam int FRONT_LAT = 5;
    localparam int LANE_LAT  = DIV_STEPS + 2;
    localparam int LAT       = FRONT_LAT + LANE_LAT;

    localparam logic OP_2X2 = 1'b0;
    localparam logic OP_3X3 = 1'b1;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef logic signed [DET_W-1:0]  t_det;
endpackage

### sv/smi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small matrix inverse front end
// Forms the 3x3 or 2x2 adjugate cofactors and the determinant in five stages.
// ----------------------------------------------------------------------------
module smi_front (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic           i_op,
    input  smi_pkg::t_elem i_m [smi_pkg::N_LANES],
    output logic           o_op,
    output smi_pkg::t_det  o_det,
    output smi_pkg::t_cof  o_cof [smi_pkg::N_LANES]
);
    import smi_pkg::*;

    t_prod r_p1 [N_LANES][2];
    t_elem r_a1 [5];
    logic  r_op1;
    t_cof  r_c2 [N_LANES];
    t_elem r_a2 [5];
    logic  r_op2;
    logic signed [COF_W-1:0] r_pl3 [3];
    logic signed [COF_W-1:0] r_ph3 [3];
    t_cof  r_c3 [N_LANES];
    t_elem r_a3 [5];
    logic  r_op3;
    t_det  r_t4 [3];
    t_cof  r_c4 [N_LANES];
    t_elem r_a4 [5];
    logic  r_op4;
    t_det  r_det5;
    t_cof  r_c5 [N_LANES];
    logic  r_op5;

    t_elem a00, a01, a02, a10, a11, a12, a20, a21, a22;
    assign a00 = i_m[0];
    assign a01 = i_m[1];
    assign a02 = i_m[2];
    assign a10 = i_m[3];
    assign a11 = i_m[4];
    assign a12 = i_m[5];
    assign a20 = i_m[6];
    assign a21 = i_m[7];
    assign a22 = i_m[8];

    t_prod n_p [N_LANES][2];
    always_comb begin
        n_p[0][0] = a11 * a22; n_p[0][1] = a21 * a12;
        n_p[3][0] = a20 * a12; n_p[3][1] = a10 * a22;
        n_p[6][0] = a10 * a21; n_p[6][1] = a11 * a20;
        n_p[1][0] = a21 * a02; n_p[1][1] = a01 * a22;
        n_p[4][0] = a00 * a22; n_p[4][1] = a20 * a02;
        n_p[7][0] = a01 * a20; n_p[7][1] = a00 * a21;
        n_p[2][0] = a01 * a12; n_p[2][1] = a11 * a02;
        n_p[5][0] = a02 * a10; n_p[5][1] = a00 * a12;
        n_p[8][0] = a00 * a11; n_p[8][1] = a10 * a01;
    end

    t_det n_det3;
    assign n_det3 = r_t4[0] + r_t4[1] + r_t4[2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= n_p;
            r_a1  <= '{a00, a01, a02, a10, a11};
            r_op1 <= i_op;
            for (int l = 0; l < N_LANES; l++) begin
                r_c2[l] <= COF_W'(r_p1[l][0]) - COF_W'(r_p1[l][1]);
            end
            r_a2  <= r_a1;
            r_op2 <= r_op1;
            for (int k = 0; k < 3; k++) begin
                r_pl3[k] <= r_a2[k] * $signed({1'b0, r_c2[3*k][31:0]});
                r_ph3[k] <= r_a2[k] * $signed(r_c2[3*k][COF_W-1:32]);
            end
            r_c3  <= r_c2;
            r_a3  <= r_a2;
            r_op3 <= r_op2;
            for (int k = 0; k < 3; k++) begin
                r_t4[k] <= $signed({r_ph3[k][COF_W-1], r_ph3[k], 32'd0})
                         + $signed({{(DET_W-COF_W){r_pl3[k][COF_W-1]}}, r_pl3[k]});
            end
            r_c4  <= r_c3;
            r_a4  <= r_a3;
            r_op4 <= r_op3;
            r_op5 <= r_op4;
            if (r_op4 == OP_3X3) begin
                r_det5 <= n_det3;
                r_c5   <= r_c4;
            end else begin
                r_det5 <= DET_W'(r_c4[8]);
                for (int l = 0; l < N_LANES; l++) begin
                    case (l)
                        0: r_c5[l] <= COF_W'(r_a4[4]);
                        1: r_c5[l] <= -COF_W'(r_a4[1]);
                        3: r_c5[l] <= -COF_W'(r_a4[3]);
                        4: r_c5[l] <= COF_W'(r_a4[0]);
                        default: r_c5[l] <= '0;
                    endcase
                end
            end
        end
    end

    assign o_op  = r_op5;
    assign o_det = r_det5;
    assign o_cof = r_c5;
endmodule

### sv/smi_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small matrix inverse divider lane
// Pipelined restoring division of one cofactor by the determinant, one
// quotient bit per stage, with Q16.16 saturation at the end.
// ----------------------------------------------------------------------------
module smi_lane (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic          i_used,
    input  smi_pkg::t_cof i_cof,
    input  smi_pkg::t_det i_det,
    output logic          o_sing,
    output smi_pkg::t_elem o_res
);
    import smi_pkg::*;

    logic [DET_W-1:0]  r_dabs [DIV_STEPS+1];
    logic [DET_W-1:0]  r_rem  [DIV_STEPS+1];
    logic [ELEM_W-1:0] r_q    [DIV_STEPS+1];
    logic              r_neg  [DIV_STEPS+1];
    logic              r_ovf  [DIV_STEPS+1];
    logic              r_zero [DIV_STEPS+1];
    logic              r_sing [DIV_STEPS+1];
    t_elem             r_res;
    logic              r_sing_o;

    logic [COF_W-1:0] n_cabs;
    logic [DET_W-1:0] n_dabs;
    logic             n_sing;
    assign n_cabs = i_cof[COF_W-1] ? COF_W'(-i_cof) : COF_W'(i_cof);
    assign n_dabs = i_det[DET_W-1] ? DET_W'(-i_det) : DET_W'(i_det);
    assign n_sing = (i_det == '0);

    logic [DET_W:0]    n_two [DIV_STEPS];
    logic              n_bit [DIV_STEPS];
    logic [DET_W-1:0]  n_rem [DIV_STEPS];
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_two[k] = {r_rem[k], 1'b0};
            n_bit[k] = (n_two[k] >= {1'b0, r_dabs[k]});
            n_rem[k] = n_bit[k] ? DET_W'(n_two[k] - {1'b0, r_dabs[k]}) : DET_W'(n_two[k]);
        end
    end

    logic [ELEM_W-1:0] q;
    t_elem n_res;
    assign q = r_q[DIV_STEPS];
    always_comb begin
        if (r_zero[DIV_STEPS]) begin
            n_res = '0;
        end else if (r_neg[DIV_STEPS]) begin
            if (r_ovf[DIV_STEPS] || q > 32'h8000_0000) begin
                n_res = 32'sh8000_0000;
            end else begin
                n_res = $signed(-q);
            end
        end else begin
            if (r_ovf[DIV_STEPS] || q > 32'h7FFF_FFFF) begin
                n_res = 32'sh7FFF_FFFF;
            end else begin
                n_res = $signed(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dabs[0] <= n_dabs;
            r_rem[0]  <= DET_W'(n_cabs);
            r_q[0]    <= '0;
            r_neg[0]  <= i_cof[COF_W-1] ^ i_det[DET_W-1];
            r_ovf[0]  <= (DET_W'(n_cabs) >= n_dabs);
            r_zero[0] <= n_sing | ~i_used;
            r_sing[0] <= n_sing;
            for (int k = 0; k < DIV_STEPS; k++) begin
                r_dabs[k+1] <= r_dabs[k];
                r_rem[k+1]  <= n_rem[k];
                r_q[k+1]    <= {r_q[k][ELEM_W-2:0], n_bit[k]};
                r_neg[k+1]  <= r_neg[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_zero[k+1] <= r_zero[k];
                r_sing[k+1] <= r_sing[k];
            end
            r_res    <= n_res;
            r_sing_o <= r_sing[DIV_STEPS];
        end
    end

    assign o_res  = r_res;
    assign o_sing = r_sing_o;
endmodule

### sv/small_matrix_inverse_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small matrix inverse unit
// Inverts a 2x2 or 3x3 signed Q16.16 matrix by the adjugate method.
//
//   Channel  Handshake                  Payload
//   input    i_in_valid / o_in_ready    i_operation, i_m00 .. i_m22
//   output   o_out_valid / i_out_ready  o_singular, o_r00 .. o_r22
//
// One matrix transfer is taken every cycle unless a result waits on the output.
// The pipeline has five cofactor and determinant stages and nine divider
// lanes of 34 stages each: operand, one per quotient bit, saturation.
// When a result waits on the output, the whole pipeline holds.
// Reset clears only the valid bits of the pipeline.
// ----------------------------------------------------------------------------
module small_matrix_inverse_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_operation,
    input  smi_pkg::t_elem i_m00,
    input  smi_pkg::t_elem i_m01,
    input  smi_pkg::t_elem i_m02,
    input  smi_pkg::t_elem i_m10,
    input  smi_pkg::t_elem i_m11,
    input  smi_pkg::t_elem i_m12,
    input  smi_pkg::t_elem i_m20,
    input  smi_pkg::t_elem i_m21,
    input  smi_pkg::t_elem i_m22,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_singular,
    output smi_pkg::t_elem o_r00,
    output smi_pkg::t_elem o_r01,
    output smi_pkg::t_elem o_r02,
    output smi_pkg::t_elem o_r10,
    output smi_pkg::t_elem o_r11,
    output smi_pkg::t_elem o_r12,
    output smi_pkg::t_elem o_r20,
    output smi_pkg::t_elem o_r21,
    output smi_pkg::t_elem o_r22
);
    import smi_pkg::*;

    logic [LAT-1:0] r_vld;
    logic           en;
    t_elem          m [N_LANES];
    logic           f_op;
    t_det           f_det;
    t_cof           f_cof [N_LANES];
    logic           used [N_LANES];
    logic           sing [N_LANES];
    t_elem          res [N_LANES];

    assign en = ~r_vld[LAT-1] | i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    assign m = '{i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22};

    smi_front u_front (
        .i_clk (i_clk),
        .i_en  (en),
        .i_op  (i_operation),
        .i_m   (m),
        .o_op  (f_op),
        .o_det (f_det),
        .o_cof (f_cof)
    );

    for (genvar l = 0; l < N_LANES; l++) begin : g_lane
        assign used[l] = (f_op == OP_3X3) || (l == 0) || (l == 1) || (l == 3) || (l == 4);
        smi_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_used (used[l]),
            .i_cof  (f_cof[l]),
            .i_det  (f_det),
            .o_sing (sing[l]),
            .o_res  (res[l])
        );
    end

    assign o_singular = sing[0] & sing[4] & sing[8];
    assign o_r00 = res[0];
    assign o_r01 = res[1];
    assign o_r02 = res[2];
    assign o_r10 = res[3];
    assign o_r11 = res[4];
    assign o_r12 = res[5];
    assign o_r20 = res[6];
    assign o_r21 = res[7];
    assign o_r22 = res[8];
endmodule
